>>> sv/fplf_pkg.sv
// ----------------------------------------------------------------------------
// Four-pole ladder filter package
// Shared constants, command and status types for the filter controller and
// datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fplf_pkg;

  localparam int STAGE_COUNT = 4;
  localparam int STAGE_IDX_W = $clog2(STAGE_COUNT);

  localparam int GAIN_W   = 16;
  localparam int FBGAIN_W = 15;
  localparam int MODE_W   = 3;
  localparam int GAIN_FRAC = 16;
  localparam int FB_FRAC   = 13;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_CUTOFF   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FEEDBACK = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_MODE     = 2'd2;

  localparam logic [GAIN_W-1:0]   CUTOFF_RESET   = 16'h8000;
  localparam logic [FBGAIN_W-1:0] FEEDBACK_RESET = 15'd0;

  localparam logic [MODE_W-1:0] MODE_LP24 = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LP12 = 3'd1;
  localparam logic [MODE_W-1:0] MODE_HP24 = 3'd2;
  localparam logic [MODE_W-1:0] MODE_HP12 = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BP24 = 3'd4;
  localparam logic [MODE_W-1:0] MODE_BP12 = 3'd5;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_FB_MUL,
    OP_FB_RND,
    OP_DIFF,
    OP_MUL,
    OP_UPD,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e                    op;
    logic [STAGE_IDX_W-1:0] stage;
    logic                   fb_en;
  } fplf_cmd_t;

  typedef struct packed {
    logic lp24;
  } fplf_status_t;

endpackage

>>> sv/four_pole_ladder_filter.sv
// The next input word is taken in the cycle after the result is loaded, and the
// result waits while the output register still holds a word that is not taken.
// Words are handled one at a time, paced by the single shared multiplier: three
// steps per stage, two for the resonance feedback (LP24 mode only), and one each
// to load the input word and to load the result.
// Reset clears the four stage values and loads the register defaults
// (gain one half, no feedback, LP24); no clearing pass is needed.
// ----------------------------------------------------------------------------
// Four-pole ladder filter
// Four cascaded one-pole lowpass stages with resonance feedback and a
// selectable lowpass, highpass or bandpass output, saturated to sample range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module four_pole_ladder_filter #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fplf_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [fplf_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            sample_in_valid_i,
  output logic                            sample_in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]  sample_in_i,
  output logic                            sample_out_valid_o,
  input  logic                            sample_out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]  sample_out_o
);
  import fplf_pkg::*;

  fplf_cmd_t    cmd;
  fplf_status_t status;

  fplf_ctrl u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .sample_in_valid_i  (sample_in_valid_i),
    .sample_in_ready_o  (sample_in_ready_o),
    .sample_out_valid_o (sample_out_valid_o),
    .sample_out_ready_i (sample_out_ready_i),
    .status_i           (status),
    .cmd_o              (cmd)
  );

  fplf_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .sample_in_i  (sample_in_i),
    .sample_out_o (sample_out_o),
    .cmd_i        (cmd),
    .status_o     (status)
  );

endmodule

>>> sv/fplf_ctrl.sv
// ----------------------------------------------------------------------------
// Four-pole ladder filter controller
// Sequences the feedback product and the four stage updates over the shared
// multiplier, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fplf_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  sample_in_valid_i,
  output logic                  sample_in_ready_o,
  output logic                  sample_out_valid_o,
  input  logic                  sample_out_ready_i,
  input  fplf_pkg::fplf_status_t status_i,
  output fplf_pkg::fplf_cmd_t    cmd_o
);
  import fplf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FB_MUL,
    S_FB_RND,
    S_DIFF,
    S_MUL,
    S_UPD,
    S_OUT
  } state_e;

  state_e                 state_q, state_d;
  logic [STAGE_IDX_W-1:0] stage_q, stage_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_free;

  // The output register may be reloaded when it is empty or once its word is taken.
  assign out_free = !out_valid_q || sample_out_ready_i;

  always_comb begin
    state_d     = state_q;
    stage_d     = stage_q;
    out_valid_d = out_valid_q && !sample_out_ready_i;
    cmd_o.op    = OP_NONE;
    cmd_o.stage = stage_q;
    cmd_o.fb_en = status_i.lp24 && (stage_q == '0);
    case (state_q)
      S_IDLE: begin
        if (sample_in_valid_i) begin
          cmd_o.op = OP_LOAD;
          stage_d  = '0;
          state_d  = status_i.lp24 ? S_FB_MUL : S_DIFF;
        end
      end
      S_FB_MUL: begin
        cmd_o.op = OP_FB_MUL;
        state_d  = S_FB_RND;
      end
      S_FB_RND: begin
        cmd_o.op = OP_FB_RND;
        state_d  = S_DIFF;
      end
      S_DIFF: begin
        cmd_o.op = OP_DIFF;
        state_d  = S_MUL;
      end
      S_MUL: begin
        cmd_o.op = OP_MUL;
        state_d  = S_UPD;
      end
      S_UPD: begin
        cmd_o.op = OP_UPD;
        if (stage_q == STAGE_IDX_W'(STAGE_COUNT - 1)) begin
          state_d = S_OUT;
        end else begin
          stage_d = stage_q + 1'b1;
          state_d = S_DIFF;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.op    = OP_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stage_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stage_q     <= stage_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign sample_in_ready_o  = (state_q == S_IDLE);
  assign sample_out_valid_o = out_valid_q;

endmodule

>>> sv/fplf_dp.sv
// ----------------------------------------------------------------------------
// Four-pole ladder filter datapath
// Configuration registers, stage values, one shared multiplier with rounding,
// and the output tap selection with saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fplf_dp #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fplf_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [fplf_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample_in_i,
  output logic signed [SAMPLE_WIDTH-1:0]    sample_out_o,
  input  fplf_pkg::fplf_cmd_t                cmd_i,
  output fplf_pkg::fplf_status_t             status_o
);
  import fplf_pkg::*;

  localparam int W  = SAMPLE_WIDTH;
  localparam int DW = W + 3;
  localparam int PW = DW + 17;

  localparam logic signed [PW-1:0] GAIN_HALF = PW'(1) << (GAIN_FRAC - 1);
  localparam logic signed [PW-1:0] FB_HALF   = PW'(1) << (FB_FRAC - 1);
  localparam logic signed [DW:0] SMAX = {{(DW - W + 2){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [DW:0] SMIN = {{(DW - W + 2){1'b1}}, {(W - 1){1'b0}}};

  logic [GAIN_W-1:0]   cutoff_q;
  logic [FBGAIN_W-1:0] fbgain_q;
  logic [MODE_W-1:0]   mode_q;

  logic signed [W-1:0]  stage_q [STAGE_COUNT];
  logic signed [W-1:0]  in_q;
  logic signed [W-1:0]  cur_q;
  logic signed [DW-1:0] fb_q;
  logic signed [DW-1:0] diff_q;
  logic signed [PW-1:0] prod_q;
  logic signed [W-1:0]  out_q;

  logic signed [W-1:0]  stage_sel;
  logic signed [DW-1:0] mul_a;
  logic signed [16:0]   mul_b;
  logic signed [PW-1:0] prod_d;
  logic signed [PW-1:0] fb_sum;
  logic signed [PW-1:0] fb_shift;
  logic signed [PW-1:0] gain_sum;
  logic signed [PW-1:0] gain_shift;
  logic signed [DW-1:0] diff_d;
  logic signed [DW:0]   upd_sum;
  logic signed [W-1:0]  upd_val;
  logic signed [DW:0]   res_full;
  logic signed [W-1:0]  res_val;

  function automatic logic signed [W-1:0] sat(input logic signed [DW:0] v);
    logic signed [W-1:0] r;
    if (v > SMAX) begin
      r = SMAX[W-1:0];
    end else if (v < SMIN) begin
      r = SMIN[W-1:0];
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [DW:0] ext(input logic signed [W-1:0] v);
    return {{(DW - W + 1){v[W-1]}}, v};
  endfunction

  assign status_o.lp24 = (mode_q == MODE_LP24);
  assign stage_sel     = stage_q[cmd_i.stage];

  // The multiplier is shared between the feedback product and the stage gain.
  always_comb begin
    if (cmd_i.op == OP_FB_MUL) begin
      mul_a = {{3{stage_q[STAGE_COUNT-1][W-1]}}, stage_q[STAGE_COUNT-1]};
      mul_b = {2'b00, fbgain_q};
    end else begin
      mul_a = diff_q;
      mul_b = {1'b0, cutoff_q};
    end
    prod_d = PW'(mul_a) * PW'(mul_b);
  end

  // Round to nearest, ties toward plus infinity, by adding half and flooring.
  assign fb_sum     = prod_q + FB_HALF;
  assign fb_shift   = fb_sum >>> FB_FRAC;
  assign gain_sum   = prod_q + GAIN_HALF;
  assign gain_shift = gain_sum >>> GAIN_FRAC;

  assign diff_d  = DW'(cur_q) - DW'(stage_sel) - (cmd_i.fb_en ? fb_q : '0);
  assign upd_sum = ext(stage_sel) + {gain_shift[DW-1], gain_shift[DW-1:0]};
  assign upd_val = sat(upd_sum);

  always_comb begin
    case (mode_q)
      MODE_LP12: res_full = ext(stage_q[1]);
      MODE_HP24: res_full = ext(in_q) - ext(stage_q[3]);
      MODE_HP12: res_full = ext(in_q) - ext(stage_q[1]);
      MODE_BP24: res_full = ext(stage_q[1]) - ext(stage_q[3]);
      MODE_BP12: res_full = ext(stage_q[0]) - ext(stage_q[2]);
      default:   res_full = ext(stage_q[3]);
    endcase
  end
  assign res_val = sat(res_full);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= CUTOFF_RESET;
      fbgain_q <= FEEDBACK_RESET;
      mode_q   <= MODE_LP24;
      for (int i = 0; i < STAGE_COUNT; i++) begin
        stage_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_CUTOFF:   cutoff_q <= cfg_wdata_i[GAIN_W-1:0];
          CFG_FEEDBACK: fbgain_q <= cfg_wdata_i[FBGAIN_W-1:0];
          CFG_MODE:     mode_q   <= cfg_wdata_i[MODE_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.op == OP_UPD) begin
        stage_q[cmd_i.stage] <= upd_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        in_q  <= sample_in_i;
        cur_q <= sample_in_i;
      end
      OP_FB_MUL: prod_q <= prod_d;
      OP_FB_RND: fb_q   <= fb_shift[DW-1:0];
      OP_DIFF:   diff_q <= diff_d;
      OP_MUL:    prod_q <= prod_d;
      OP_UPD:    cur_q  <= upd_val;
      OP_OUT:    out_q  <= res_val;
      default: begin
      end
    endcase
  end

  assign sample_out_o = out_q;

endmodule
